@@ src/bol_pkg.sv @@
// ---------------------------------------------------------------------------
// bol_pkg: shared types and constants of the bounded ordered list unit
// Command and status codes, sequencer states and the fixed field widths.
// ---------------------------------------------------------------------------
package bol_pkg;

   // Fixed field widths
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 3;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // Default list depth
   localparam int CAPACITY_DEF = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_ERASE  = 3'd3,
      CMD_READ   = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_UP_CHECK,
      S_UP_MOVE,
      S_DOWN_CHECK,
      S_DOWN_MOVE,
      S_READ_WAIT,
      S_FINISH
   } state_type;

endpackage

@@ src/bounded_ordered_list_unit.sv @@
// ---------------------------------------------------------------------------
// bounded_ordered_list_unit: ordered list of signed 32-bit values
// Append, remove last, insert, erase, read and clear on a list of up to
// CAPACITY elements; one result per command.
// ---------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  command, position, value
//  rsp_      out        rsp_valid/rsp_stall  read_value, count, status
//
//  Append, remove, clear and rejected commands go from the execute step
//  straight to the finish step, and read adds a wait step. Insert moves
//  count - position elements and erase count - position - 1, count taken
//  before the item: each moved element is a check step that reads it and
//  a move step that writes it, as the element store registers read data.
//  req_stall stays high until the result is placed in the output register;
//  a stalled result holds while the next item is accepted and worked on.
//  Synchronous active-high reset empties the list; elements are not cleared.
// ---------------------------------------------------------------------------
module bounded_ordered_list_unit #(
   parameter int CAPACITY = bol_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bol_pkg::CMD_W-1:0]         req_command,
   input  logic [bol_pkg::POS_W-1:0]         req_position,
   input  logic signed [bol_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [bol_pkg::DATA_W-1:0] rsp_read_value,
   output logic [bol_pkg::COUNT_W-1:0]       rsp_count,
   output logic [bol_pkg::STATUS_W-1:0]      rsp_status
);

   localparam int ADDR_W = $clog2(CAPACITY);

   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_waddr;
   logic [bol_pkg::DATA_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]          mem_raddr;
   logic [bol_pkg::DATA_W-1:0] mem_rdata;

   // Command sequencer
   bol_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_status     (rsp_status),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata)
   );

   // Element store
   bol_mem #(
      .CAPACITY (CAPACITY)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

@@ src/bol_step.sv @@
// ---------------------------------------------------------------------------
// bol_step: shared index step unit
// One incrementer/decrementer and one compare, reused on every move step of
// insert and erase.
// ---------------------------------------------------------------------------
module bol_step #(
   parameter int IDX_W = 5
) (
   input  logic [IDX_W-1:0] idx,
   input  logic             step_up,
   input  logic [IDX_W-1:0] limit,
   output logic [IDX_W-1:0] nbr,
   output logic             reached
);

   // Step toward the neighbor that moves next
   assign nbr = step_up ? (idx + IDX_W'(1)) : (idx - IDX_W'(1));

   // Moving down stops at the insert position, moving up at the fill count
   assign reached = step_up ? (nbr >= limit) : (idx == limit);

endmodule

@@ src/bol_mem.sv @@
// ---------------------------------------------------------------------------
// bol_mem: element storage of the list
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bol_mem #(
   parameter int CAPACITY = bol_pkg::CAPACITY_DEF,
   localparam int ADDR_W  = $clog2(CAPACITY)
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [ADDR_W-1:0]          waddr,
   input  logic [bol_pkg::DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0]          raddr,
   output logic [bol_pkg::DATA_W-1:0] rdata
);

   logic [bol_pkg::DATA_W-1:0] mem [CAPACITY];
   logic [bol_pkg::DATA_W-1:0] rdata_ff;

   // Write the element, register the read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/bol_ctrl.sv @@
// ---------------------------------------------------------------------------
// bol_ctrl: command sequencer of the bounded ordered list unit
// Checks each command, steps the shared index unit over the elements that
// move, holds the fill count and the result register.
// ---------------------------------------------------------------------------
module bol_ctrl #(
   parameter int CAPACITY = bol_pkg::CAPACITY_DEF,
   localparam int ADDR_W  = $clog2(CAPACITY),
   localparam int FILL_W  = $clog2(CAPACITY + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bol_pkg::CMD_W-1:0]         req_command,
   input  logic [bol_pkg::POS_W-1:0]         req_position,
   input  logic signed [bol_pkg::DATA_W-1:0] req_value,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [bol_pkg::DATA_W-1:0] rsp_read_value,
   output logic [bol_pkg::COUNT_W-1:0]       rsp_count,
   output logic [bol_pkg::STATUS_W-1:0]      rsp_status,
   // element storage
   output logic                              mem_we,
   output logic [ADDR_W-1:0]                 mem_waddr,
   output logic [bol_pkg::DATA_W-1:0]        mem_wdata,
   output logic [ADDR_W-1:0]                 mem_raddr,
   input  logic [bol_pkg::DATA_W-1:0]        mem_rdata
);

   localparam int CMP_W = (FILL_W > bol_pkg::POS_W) ? FILL_W : bol_pkg::POS_W;
   localparam int CNT_W = (FILL_W > bol_pkg::COUNT_W) ? FILL_W : bol_pkg::COUNT_W;

   bol_pkg::state_type  state_ff, state_in;
   bol_pkg::cmd_type    cmd_ff, cmd_in;
   bol_pkg::status_type status_ff, status_in;
   logic [CMP_W-1:0]    pos_ff, pos_in;
   logic [CMP_W-1:0]    idx_ff, idx_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [bol_pkg::DATA_W-1:0] val_ff, val_in;
   logic [bol_pkg::DATA_W-1:0] rd_ff, rd_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bol_pkg::DATA_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [bol_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [bol_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic             step_up;
   logic [CMP_W-1:0] step_limit;
   logic [CMP_W-1:0] step_nbr;
   logic             step_reached;

   logic             is_full, is_empty, pos_gt_fill, pos_ge_fill, out_free;
   logic [CMP_W-1:0] fill_cmp;
   logic [CNT_W-1:0] fill_cnt;

   // Shared index step unit
   bol_step #(
      .IDX_W (CMP_W)
   ) u_step (
      .idx     (idx_ff),
      .step_up (step_up),
      .limit   (step_limit),
      .nbr     (step_nbr),
      .reached (step_reached)
   );

   // Command checks
   assign fill_cmp    = CMP_W'(fill_ff);
   assign fill_cnt    = CNT_W'(fill_ff);
   assign is_full     = (fill_ff == FILL_W'(CAPACITY));
   assign is_empty    = (fill_ff == '0);
   assign pos_gt_fill = (pos_ff > fill_cmp);
   assign pos_ge_fill = (pos_ff >= fill_cmp);
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // Step direction and limit follow the move phase
   assign step_up    = (state_ff == bol_pkg::S_DOWN_CHECK) ||
                       (state_ff == bol_pkg::S_DOWN_MOVE);
   assign step_limit = step_up ? fill_cmp : pos_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bol_pkg::S_IDLE: begin
            if (req_valid) state_in = bol_pkg::S_EXEC;
         end
         bol_pkg::S_EXEC: begin
            state_in = bol_pkg::S_FINISH;
            unique case (cmd_ff)
               bol_pkg::CMD_INSERT: begin
                  if (!pos_gt_fill && !is_full) state_in = bol_pkg::S_UP_CHECK;
               end
               bol_pkg::CMD_ERASE: begin
                  if (!is_empty && !pos_ge_fill) state_in = bol_pkg::S_DOWN_CHECK;
               end
               bol_pkg::CMD_READ: begin
                  if (!is_empty && !pos_ge_fill) state_in = bol_pkg::S_READ_WAIT;
               end
               default: begin
                  state_in = bol_pkg::S_FINISH;
               end
            endcase
         end
         bol_pkg::S_UP_CHECK: begin
            state_in = step_reached ? bol_pkg::S_FINISH : bol_pkg::S_UP_MOVE;
         end
         bol_pkg::S_UP_MOVE: begin
            state_in = bol_pkg::S_UP_CHECK;
         end
         bol_pkg::S_DOWN_CHECK: begin
            state_in = step_reached ? bol_pkg::S_FINISH : bol_pkg::S_DOWN_MOVE;
         end
         bol_pkg::S_DOWN_MOVE: begin
            state_in = bol_pkg::S_DOWN_CHECK;
         end
         bol_pkg::S_READ_WAIT: begin
            state_in = bol_pkg::S_FINISH;
         end
         bol_pkg::S_FINISH: begin
            if (out_free) state_in = bol_pkg::S_IDLE;
         end
         default: begin
            state_in = bol_pkg::S_IDLE;
         end
      endcase
   end

   // Datapath and storage controls
   always_comb begin
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      fill_in       = fill_ff;
      rd_in         = rd_ff;
      status_in     = status_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[ADDR_W-1:0];
      mem_wdata     = val_ff;
      mem_raddr     = step_nbr[ADDR_W-1:0];
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         bol_pkg::S_IDLE: begin
            // latch the item
            if (req_valid) begin
               cmd_in    = bol_pkg::cmd_type'(req_command);
               pos_in    = CMP_W'(req_position);
               val_in    = req_value;
               rd_in     = '0;
               status_in = bol_pkg::STAT_DONE;
            end
         end
         bol_pkg::S_EXEC: begin
            mem_raddr = pos_ff[ADDR_W-1:0];
            unique case (cmd_ff)
               bol_pkg::CMD_APPEND: begin
                  if (is_full) begin
                     status_in = bol_pkg::STAT_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = fill_cmp[ADDR_W-1:0];
                     fill_in   = fill_ff + FILL_W'(1);
                  end
               end
               bol_pkg::CMD_REMOVE: begin
                  if (is_empty) status_in = bol_pkg::STAT_EMPTY;
                  else          fill_in   = fill_ff - FILL_W'(1);
               end
               bol_pkg::CMD_INSERT: begin
                  priority if (pos_gt_fill) status_in = bol_pkg::STAT_RANGE;
                  else if (is_full)         status_in = bol_pkg::STAT_FULL;
                  else                      idx_in    = fill_cmp;
               end
               bol_pkg::CMD_ERASE: begin
                  priority if (is_empty) status_in = bol_pkg::STAT_EMPTY;
                  else if (pos_ge_fill)  status_in = bol_pkg::STAT_RANGE;
                  else                   idx_in    = pos_ff;
               end
               bol_pkg::CMD_READ: begin
                  priority if (is_empty) status_in = bol_pkg::STAT_EMPTY;
                  else if (pos_ge_fill)  status_in = bol_pkg::STAT_RANGE;
               end
               bol_pkg::CMD_CLEAR: begin
                  fill_in = '0;
               end
               default: begin
                  status_in = bol_pkg::STAT_DONE;
               end
            endcase
         end
         bol_pkg::S_UP_CHECK: begin
            // at the insert position: drop the new value in
            if (step_reached) begin
               mem_we  = 1'b1;
               fill_in = fill_ff + FILL_W'(1);
            end
         end
         bol_pkg::S_UP_MOVE: begin
            // move the lower neighbor up one place
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
            idx_in    = step_nbr;
         end
         bol_pkg::S_DOWN_CHECK: begin
            if (step_reached) fill_in = fill_ff - FILL_W'(1);
         end
         bol_pkg::S_DOWN_MOVE: begin
            // move the upper neighbor down one place
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
            idx_in    = step_nbr;
         end
         bol_pkg::S_READ_WAIT: begin
            rd_in = mem_rdata;
         end
         bol_pkg::S_FINISH: begin
            // hand the result to the output register once it is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_ff;
               rsp_count_in  = fill_cnt[bol_pkg::COUNT_W-1:0];
               rsp_status_in = status_ff;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bol_pkg::S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      rd_ff         <= rd_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall      = (state_ff != bol_pkg::S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

   // Fill count never passes the capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CAPACITY))
      else $error("fill count above capacity");

   // An accepted item always starts its check step
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == bol_pkg::S_EXEC))
      else $error("accepted item did not enter the check step");

   // A new result comes only out of the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bol_pkg::S_FINISH))
      else $error("result raised outside the finish step");

   // Storage is written only while a command is at work
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff != bol_pkg::S_IDLE && state_ff != bol_pkg::S_FINISH))
      else $error("element write while idle");

endmodule
